// ----- rtl/rfv_pkg.sv -----
// ----------------------------------------------------------------------------
// rfv_pkg
// Types and constants shared by the reply frame validator.
// ----------------------------------------------------------------------------
package rfv_pkg;

	localparam int LENGTH_BITS_DEF = 30;
	localparam logic [15:0] MAX_ELEMENTS_RST = 16'd1024;

	// frame_status codes
	localparam logic [1:0] ST_MORE  = 2'd0;
	localparam logic [1:0] ST_DONE  = 2'd1;
	localparam logic [1:0] ST_ERROR = 2'd2;

	// reply_kind codes
	localparam logic [2:0] KIND_STATUS  = 3'd0;
	localparam logic [2:0] KIND_ERRTEXT = 3'd1;
	localparam logic [2:0] KIND_INTEGER = 3'd2;
	localparam logic [2:0] KIND_BULK    = 3'd3;
	localparam logic [2:0] KIND_MULTI   = 3'd4;
	localparam logic [2:0] KIND_UNKNOWN = 3'd5;

	// framing characters
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR  = 8'h2a;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       frame_start;
	} req_t;

	typedef struct packed {
		logic [1:0] frame_status;
		logic [2:0] reply_kind;
	} rsp_t;

endpackage

// ----- rtl/reply_frame_validator.sv -----
// ----------------------------------------------------------------------------
// reply_frame_validator
// The result of an accepted request is registered in the output register.
// Throughput: one byte per cycle while the output is not stalled; the parser state update is a single pass
// of logic from the state registers back into themselves.
// Reset: arst_n clears parser state and the output valid flag (not the output data) and sets
// max_elements to 1024; frame_start clears parser state but not max_elements.
// ----------------------------------------------------------------------------
module reply_frame_validator #(
	parameter int LENGTH_BITS = rfv_pkg::LENGTH_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          max_elements_we,
	input  logic [15:0]   max_elements_wdata,
	input  logic          req_valid,
	output logic          req_stall,
	input  rfv_pkg::req_t req_data,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output rfv_pkg::rsp_t rsp_data
);

	localparam logic [3:0] PH_TYPE      = 4'd0;
	localparam logic [3:0] PH_LINE      = 4'd1;
	localparam logic [3:0] PH_LEN_NUM   = 4'd2;
	localparam logic [3:0] PH_LEN_LF    = 4'd3;
	localparam logic [3:0] PH_DATA      = 4'd4;
	localparam logic [3:0] PH_DATA_CR   = 4'd5;
	localparam logic [3:0] PH_DATA_LF   = 4'd6;
	localparam logic [3:0] PH_ELEM_TYPE = 4'd7;
	localparam logic [3:0] PH_CNT_NUM   = 4'd8;
	localparam logic [3:0] PH_CNT_LF    = 4'd9;

	localparam int CW = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;
	localparam int MW = LENGTH_BITS + 4;

	logic [15:0]            max_elements_q;
	logic [3:0]             phase_q, phase_c, phase_n;
	logic [2:0]             kind_q, kind_c, kind_n;
	logic [15:0]            elems_q, elems_c, elems_n;
	logic [LENGTH_BITS-1:0] payload_q, payload_c, payload_n;
	logic [LENGTH_BITS-1:0] num_q, num_c, num_n;
	logic                   neg_q, neg_c, neg_n;
	logic                   dig_q, dig_c, dig_n;
	logic                   cr_q, cr_c, cr_n;
	logic                   err_q, err_c, err_n;
	logic                   done_q, done_c, done_n;

	logic                   rsp_valid_q;
	rfv_pkg::rsp_t          rsp_data_q;
	logic                   accept;

	logic [7:0]             b;
	logic                   is_digit;
	logic [MW-1:0]          num_ext, num_mul;
	logic                   num_ovf;
	logic [CW-1:0]          num_cw, max_cw;
	logic [15:0]            elems_dec;
	logic [LENGTH_BITS-1:0] payload_dec;

	assign accept    = req_valid && !req_stall;
	assign req_stall = rsp_valid_q && rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_data_q;

	assign b        = req_data.data_byte;
	assign is_digit = (b >= rfv_pkg::CH_ZERO) && (b <= rfv_pkg::CH_NINE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_elements_q <= rfv_pkg::MAX_ELEMENTS_RST;
		end else if (max_elements_we) begin
			max_elements_q <= max_elements_wdata;
		end
	end

	// frame_start restarts the parser on this very byte
	always_comb begin
		if (req_data.frame_start) begin
			phase_c   = PH_TYPE;
			kind_c    = rfv_pkg::KIND_UNKNOWN;
			elems_c   = '0;
			payload_c = '0;
			num_c     = '0;
			neg_c     = 1'b0;
			dig_c     = 1'b0;
			cr_c      = 1'b0;
			err_c     = 1'b0;
			done_c    = 1'b0;
		end else begin
			phase_c   = phase_q;
			kind_c    = kind_q;
			elems_c   = elems_q;
			payload_c = payload_q;
			num_c     = num_q;
			neg_c     = neg_q;
			dig_c     = dig_q;
			cr_c      = cr_q;
			err_c     = err_q;
			done_c    = done_q;
		end
	end

	assign num_ext     = MW'(num_c);
	assign num_mul     = (num_ext << 3) + (num_ext << 1) + MW'(b[3:0]);
	assign num_ovf     = |num_mul[MW-1:LENGTH_BITS];
	assign num_cw      = CW'(num_c);
	assign max_cw      = CW'(max_elements_q);
	assign elems_dec   = elems_c - 16'd1;
	assign payload_dec = payload_c - LENGTH_BITS'(1);

	always_comb begin
		phase_n   = phase_c;
		kind_n    = kind_c;
		elems_n   = elems_c;
		payload_n = payload_c;
		num_n     = num_c;
		neg_n     = neg_c;
		dig_n     = dig_c;
		cr_n      = cr_c;
		err_n     = err_c;
		done_n    = done_c;

		if (!err_c) begin
			if (done_c) begin
				err_n = 1'b1;
			end else begin
				case (phase_c)
					PH_TYPE: begin
						cr_n  = 1'b0;
						num_n = '0;
						neg_n = 1'b0;
						dig_n = 1'b0;
						if (b == rfv_pkg::CH_PLUS) begin
							kind_n  = rfv_pkg::KIND_STATUS;
							phase_n = PH_LINE;
						end else if (b == rfv_pkg::CH_MINUS) begin
							kind_n  = rfv_pkg::KIND_ERRTEXT;
							phase_n = PH_LINE;
						end else if (b == rfv_pkg::CH_COLON) begin
							kind_n  = rfv_pkg::KIND_INTEGER;
							phase_n = PH_LINE;
						end else if (b == rfv_pkg::CH_DOLLAR) begin
							kind_n  = rfv_pkg::KIND_BULK;
							phase_n = PH_LEN_NUM;
						end else if (b == rfv_pkg::CH_STAR) begin
							kind_n  = rfv_pkg::KIND_MULTI;
							phase_n = PH_CNT_NUM;
						end else begin
							err_n = 1'b1;
							num_n = num_c;
							neg_n = neg_c;
							dig_n = dig_c;
						end
					end
					PH_LINE: begin
						if (cr_c && b == rfv_pkg::CH_LF)
							done_n = 1'b1;
						cr_n = (b == rfv_pkg::CH_CR);
					end
					PH_LEN_NUM, PH_CNT_NUM: begin
						if (b == rfv_pkg::CH_MINUS && !dig_c && !neg_c) begin
							neg_n = 1'b1;
						end else if (is_digit) begin
							if (num_ovf) begin
								err_n = 1'b1;
							end else begin
								num_n = num_mul[LENGTH_BITS-1:0];
								dig_n = 1'b1;
							end
						end else if (b == rfv_pkg::CH_CR && dig_c) begin
							phase_n = (phase_c == PH_LEN_NUM) ? PH_LEN_LF : PH_CNT_LF;
						end else begin
							err_n = 1'b1;
						end
					end
					PH_LEN_LF: begin
						if (b != rfv_pkg::CH_LF) begin
							err_n = 1'b1;
						end else if (neg_c && num_c > LENGTH_BITS'(1)) begin
							err_n = 1'b1;
						end else if (neg_c && num_c == LENGTH_BITS'(1)) begin
							// null bulk: element ends here
							if (kind_c == rfv_pkg::KIND_MULTI) begin
								elems_n = elems_dec;
								if (elems_dec == 16'd0)
									done_n = 1'b1;
								else
									phase_n = PH_ELEM_TYPE;
							end else begin
								done_n = 1'b1;
							end
						end else begin
							payload_n = num_c;
							phase_n   = (num_c == '0) ? PH_DATA_CR : PH_DATA;
						end
					end
					PH_CNT_LF: begin
						if (b != rfv_pkg::CH_LF) begin
							err_n = 1'b1;
						end else if ((neg_c && num_c != '0) || num_cw > max_cw) begin
							err_n = 1'b1;
						end else if (num_c == '0) begin
							done_n = 1'b1;
						end else begin
							elems_n = num_cw[15:0];
							phase_n = PH_ELEM_TYPE;
						end
					end
					PH_DATA: begin
						payload_n = payload_dec;
						if (payload_dec == '0)
							phase_n = PH_DATA_CR;
					end
					PH_DATA_CR: begin
						if (b != rfv_pkg::CH_CR)
							err_n = 1'b1;
						else
							phase_n = PH_DATA_LF;
					end
					PH_DATA_LF: begin
						if (b != rfv_pkg::CH_LF) begin
							err_n = 1'b1;
						end else if (kind_c == rfv_pkg::KIND_MULTI) begin
							elems_n = elems_dec;
							if (elems_dec == 16'd0)
								done_n = 1'b1;
							else
								phase_n = PH_ELEM_TYPE;
						end else begin
							done_n = 1'b1;
						end
					end
					PH_ELEM_TYPE: begin
						if (b != rfv_pkg::CH_DOLLAR) begin
							err_n = 1'b1;
						end else begin
							num_n   = '0;
							neg_n   = 1'b0;
							dig_n   = 1'b0;
							phase_n = PH_LEN_NUM;
						end
					end
					default: begin
						err_n = 1'b1;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_TYPE;
			kind_q    <= rfv_pkg::KIND_UNKNOWN;
			elems_q   <= '0;
			payload_q <= '0;
			num_q     <= '0;
			neg_q     <= 1'b0;
			dig_q     <= 1'b0;
			cr_q      <= 1'b0;
			err_q     <= 1'b0;
			done_q    <= 1'b0;
		end else if (accept) begin
			phase_q   <= phase_n;
			kind_q    <= kind_n;
			elems_q   <= elems_n;
			payload_q <= payload_n;
			num_q     <= num_n;
			neg_q     <= neg_n;
			dig_q     <= dig_n;
			cr_q      <= cr_n;
			err_q     <= err_n;
			done_q    <= done_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_data_q.frame_status <= err_n ? rfv_pkg::ST_ERROR :
				(done_n ? rfv_pkg::ST_DONE : rfv_pkg::ST_MORE);
			rsp_data_q.reply_kind   <= kind_n;
		end
	end

`ifndef ASSERT_OFF
	// error stays set until the next frame_start
	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		err_q && accept && !req_data.frame_start |=> err_q)
		else $error("sticky error cleared without frame_start");

	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> rsp_valid)
		else $error("accepted request produced no result");

	a_payload_live: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA |-> payload_q != '0)
		else $error("data phase with no payload left");

	a_kind_known: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != PH_TYPE |-> kind_q != rfv_pkg::KIND_UNKNOWN)
		else $error("parser past type byte with unknown kind");

	a_elems_live: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_ELEM_TYPE |-> elems_q != 16'd0 && kind_q == rfv_pkg::KIND_MULTI)
		else $error("element phase with no element pending");
`endif

endmodule

// ----- tb/rfv_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rfv_checker
// Watches both channels of the reply frame validator, tracks the framing
// state of the byte stream on its own and compares every result with the
// status and reply kind it predicts.
// ----------------------------------------------------------------------------
module rfv_checker #(
	parameter int LENGTH_BITS = rfv_pkg::LENGTH_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          max_elements_we,
	input  logic [15:0]   max_elements_wdata,
	input  logic          req_valid,
	input  logic          req_stall,
	input  rfv_pkg::req_t req_data,
	input  logic          rsp_valid,
	input  logic          rsp_stall,
	input  rfv_pkg::rsp_t rsp_data,
	output int            fail_count,
	output int            open_count,
	output int            done_count,
	output int            error_count
);

	typedef enum logic [3:0] {
		PH_TYPE, PH_LINE, PH_LEN_NUM, PH_LEN_LF, PH_DATA,
		PH_DATA_CR, PH_DATA_LF, PH_ELEM_TYPE, PH_CNT_NUM, PH_CNT_LF
	} phase_e;

	localparam logic [39:0] NUM_LIMIT = (40'd1 << LENGTH_BITS) - 40'd1;

	// tracked framing state
	phase_e      ph;
	logic [2:0]  kind;
	logic [15:0] elems_left;
	logic [30:0] bytes_left;
	logic [39:0] num;
	logic        neg;
	logic        digit;
	logic        last_cr;
	logic        err;
	logic        done;
	logic [15:0] max_elem;

	rfv_pkg::rsp_t status_q[$];
	int   fails;
	int   n_done;
	int   n_err;

	assign fail_count  = fails;
	assign done_count  = n_done;
	assign error_count = n_err;

	task automatic clear_parse();
		ph         = PH_TYPE;
		kind       = rfv_pkg::KIND_UNKNOWN;
		elems_left = '0;
		bytes_left = '0;
		num        = '0;
		neg        = 1'b0;
		digit      = 1'b0;
		last_cr    = 1'b0;
		err        = 1'b0;
		done       = 1'b0;
	endtask

	task automatic start_number(input phase_e p);
		num   = '0;
		neg   = 1'b0;
		digit = 1'b0;
		ph    = p;
	endtask

	// res: 0 keep going, 1 closing CR seen, -1 malformed header
	task automatic number_step(input logic [7:0] b, output int res);
		logic [39:0] v;
		logic [39:0] d;
		res = -1;
		d = {32'd0, b} - {32'd0, rfv_pkg::CH_ZERO};
		if (b == rfv_pkg::CH_MINUS && !digit && !neg) begin
			neg = 1'b1;
			res = 0;
		end else if (b >= rfv_pkg::CH_ZERO && b <= rfv_pkg::CH_NINE) begin
			v = num * 40'd10 + d;
			if (v <= NUM_LIMIT) begin
				num   = v;
				digit = 1'b1;
				res   = 0;
			end
		end else if (b == rfv_pkg::CH_CR) begin
			res = digit ? 1 : -1;
		end
	endtask

	task automatic element_finish();
		if (kind == rfv_pkg::KIND_MULTI) begin
			elems_left = elems_left - 16'd1;
			if (elems_left == 16'd0)
				done = 1'b1;
			else
				ph = PH_ELEM_TYPE;
		end else begin
			done = 1'b1;
		end
	endtask

	task automatic parse_byte(input logic [7:0] b);
		int res;
		case (ph)
			PH_TYPE: begin
				if (b == rfv_pkg::CH_PLUS) begin
					kind = rfv_pkg::KIND_STATUS;
					ph = PH_LINE;
				end else if (b == rfv_pkg::CH_MINUS) begin
					kind = rfv_pkg::KIND_ERRTEXT;
					ph = PH_LINE;
				end else if (b == rfv_pkg::CH_COLON) begin
					kind = rfv_pkg::KIND_INTEGER;
					ph = PH_LINE;
				end else if (b == rfv_pkg::CH_DOLLAR) begin
					kind = rfv_pkg::KIND_BULK;
					start_number(PH_LEN_NUM);
				end else if (b == rfv_pkg::CH_STAR) begin
					kind = rfv_pkg::KIND_MULTI;
					start_number(PH_CNT_NUM);
				end else begin
					err = 1'b1;
				end
				last_cr = 1'b0;
			end
			PH_LINE: begin
				if (last_cr && b == rfv_pkg::CH_LF)
					done = 1'b1;
				last_cr = (b == rfv_pkg::CH_CR);
			end
			PH_LEN_NUM, PH_CNT_NUM: begin
				number_step(b, res);
				if (res < 0)
					err = 1'b1;
				else if (res > 0)
					ph = (ph == PH_LEN_NUM) ? PH_LEN_LF : PH_CNT_LF;
			end
			PH_LEN_LF: begin
				if (b != rfv_pkg::CH_LF)
					err = 1'b1;
				else if (neg && num > 40'd1)
					err = 1'b1;
				else if (neg && num == 40'd1)
					element_finish();  // null bulk
				else begin
					bytes_left = num[30:0];
					ph = (num == 40'd0) ? PH_DATA_CR : PH_DATA;
				end
			end
			PH_CNT_LF: begin
				if (b != rfv_pkg::CH_LF)
					err = 1'b1;
				else if ((neg && num != 40'd0) || num > {24'd0, max_elem})
					err = 1'b1;
				else if (num == 40'd0)
					done = 1'b1;
				else begin
					elems_left = num[15:0];
					ph = PH_ELEM_TYPE;
				end
			end
			PH_DATA: begin
				bytes_left = bytes_left - 31'd1;
				if (bytes_left == 31'd0)
					ph = PH_DATA_CR;
			end
			PH_DATA_CR: begin
				if (b != rfv_pkg::CH_CR)
					err = 1'b1;
				else
					ph = PH_DATA_LF;
			end
			PH_DATA_LF: begin
				if (b != rfv_pkg::CH_LF)
					err = 1'b1;
				else
					element_finish();
			end
			PH_ELEM_TYPE: begin
				if (b != rfv_pkg::CH_DOLLAR)
					err = 1'b1;
				else
					start_number(PH_LEN_NUM);
			end
			default: err = 1'b1;
		endcase
	endtask

	task automatic predict_status(input rfv_pkg::req_t r, output rfv_pkg::rsp_t e);
		if (r.frame_start)
			clear_parse();
		if (!err) begin
			// anything after a complete reply without frame_start is an error
			if (done)
				err = 1'b1;
			else
				parse_byte(r.data_byte);
		end
		e.frame_status = err ? rfv_pkg::ST_ERROR :
			(done ? rfv_pkg::ST_DONE : rfv_pkg::ST_MORE);
		e.reply_kind   = kind;
	endtask

	always @(posedge clk or negedge arst_n) begin
		rfv_pkg::rsp_t want;
		rfv_pkg::rsp_t pred;
		if (!arst_n) begin
			clear_parse();
			max_elem = rfv_pkg::MAX_ELEMENTS_RST;
			status_q.delete();
			fails  = 0;
			n_done = 0;
			n_err  = 0;
			open_count <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (status_q.size() == 0) begin
					$display("%0t: result with nothing expected, actual status %0d kind %0d",
						$time, rsp_data.frame_status, rsp_data.reply_kind);
					fails++;
				end else begin
					want = status_q.pop_front();
					if (rsp_data.frame_status !== want.frame_status) begin
						$display("%0t: frame_status mismatch, expected %0d actual %0d",
							$time, want.frame_status, rsp_data.frame_status);
						fails++;
					end
					if (rsp_data.reply_kind !== want.reply_kind) begin
						$display("%0t: reply_kind mismatch, expected %0d actual %0d",
							$time, want.reply_kind, rsp_data.reply_kind);
						fails++;
					end
				end
			end
			if (req_valid && !req_stall) begin
				predict_status(req_data, pred);
				if (pred.frame_status == rfv_pkg::ST_DONE)
					n_done++;
				if (pred.frame_status == rfv_pkg::ST_ERROR)
					n_err++;
				status_q.push_back(pred);
			end
			if (max_elements_we)
				max_elem = max_elements_wdata;
			open_count <= status_q.size();
		end
	end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the reply frame validator with directed replies, then with random
// well-formed, broken and noisy reply streams under three idling modes and
// several max_elements settings; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int CYCLE_LIMIT = 200000;
	localparam int LONG_HOLD   = 60;
	localparam int SETTLE      = 4;
	localparam int PHASE_ITEMS = 150;

	typedef enum int {EV_NONE, EV_LONG_HOLD, EV_PAUSE} phase_event_e;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          max_elements_we = 1'b0;
	logic [15:0]   max_elements_wdata = '0;
	logic          req_valid = 1'b0;
	logic          req_stall;
	rfv_pkg::req_t req_data = '0;
	logic          rsp_valid;
	logic          rsp_stall = 1'b0;
	rfv_pkg::rsp_t rsp_data;

	int fail_count;
	int open_count;
	int done_count;
	int error_count;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_token = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int sent_count = 0;
	int cur_max = 1024;

	rfv_pkg::req_t frame_q[$];

	always #5 clk = ~clk;

	reply_frame_validator dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.max_elements_we    (max_elements_we),
		.max_elements_wdata (max_elements_wdata),
		.req_valid          (req_valid),
		.req_stall          (req_stall),
		.req_data           (req_data),
		.rsp_valid          (rsp_valid),
		.rsp_stall          (rsp_stall),
		.rsp_data           (rsp_data)
	);

	rfv_checker chk (
		.clk                (clk),
		.arst_n             (arst_n),
		.max_elements_we    (max_elements_we),
		.max_elements_wdata (max_elements_wdata),
		.req_valid          (req_valid),
		.req_stall          (req_stall),
		.req_data           (req_data),
		.rsp_valid          (rsp_valid),
		.rsp_stall          (rsp_stall),
		.rsp_data           (rsp_data),
		.fail_count         (fail_count),
		.open_count         (open_count),
		.done_count         (done_count),
		.error_count        (error_count)
	);

	// receiver: random stall, or a long hold-off when one is asked for
	always @(negedge clk) begin
		if (hold_left > 0) begin
			rsp_stall <= 1'b1;
			hold_left = hold_left - 1;
		end else if (hold_token != hold_seen) begin
			hold_seen = hold_token;
			hold_left = LONG_HOLD - 1;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("timeout after %0d cycles, %0d results outstanding", CYCLE_LIMIT, open_count);
		$display("status: fail");
		$finish;
	end

	task automatic push_b(input logic [7:0] b, input logic st);
		rfv_pkg::req_t r;
		r.data_byte   = b;
		r.frame_start = st;
		frame_q.push_back(r);
	endtask

	task automatic push_str(input string s, input logic st);
		int i;
		for (i = 0; i < s.len(); i++)
			push_b(s[i], (i == 0) ? st : 1'b0);
	endtask

	task automatic push_crlf();
		push_b(rfv_pkg::CH_CR, 1'b0);
		push_b(rfv_pkg::CH_LF, 1'b0);
	endtask

	task automatic push_dec(input longint unsigned v);
		logic [7:0] digs[$];
		logic [7:0] d;
		longint unsigned t;
		int i;
		t = v;
		do begin
			d = 8'(t % 10);
			digs.push_front(d + rfv_pkg::CH_ZERO);
			t = t / 10;
		end while (t != 0);
		for (i = 0; i < digs.size(); i++)
			push_b(digs[i], 1'b0);
	endtask

	// one request, with random idle cycles ahead of it
	task automatic send_req(input rfv_pkg::req_t r);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req_data  <= r;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		sent_count++;
	endtask

	task automatic flush_frame();
		int i;
		for (i = 0; i < frame_q.size(); i++)
			send_req(frame_q[i]);
		frame_q.delete();
	endtask

	// sender pauses until every result has come back and the block is quiet
	task automatic drain();
		@(negedge clk);
		req_valid <= 1'b0;
		while (open_count != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_max(input int v);
		@(negedge clk);
		max_elements_we    <= 1'b1;
		max_elements_wdata <= v[15:0];
		@(negedge clk);
		max_elements_we    <= 1'b0;
		cur_max = v;
	endtask

	task automatic add_line();
		int n;
		int i;
		logic [7:0] b;
		case ($urandom_range(2))
			0: push_b(rfv_pkg::CH_PLUS, 1'b1);
			1: push_b(rfv_pkg::CH_MINUS, 1'b1);
			default: push_b(rfv_pkg::CH_COLON, 1'b1);
		endcase
		n = $urandom_range(6);
		for (i = 0; i < n; i++) begin
			b = 8'($urandom_range(255));
			if (b == rfv_pkg::CH_LF)
				b = 8'h61;  // keep the body free of an early terminator
			push_b(b, 1'b0);
		end
		push_crlf();
	endtask

	task automatic add_bulk(input logic st);
		int r;
		int n;
		int i;
		r = $urandom_range(99);
		push_b(rfv_pkg::CH_DOLLAR, st);
		if (r < 10) begin
			push_str("-1", 1'b0);
			push_crlf();
		end else begin
			if (r < 15) begin
				push_str("-0", 1'b0);
				n = 0;
			end else begin
				n = (r < 20) ? $urandom_range(40) : $urandom_range(6);
				push_dec(64'(n));
			end
			push_crlf();
			for (i = 0; i < n; i++)
				push_b(8'($urandom_range(255)), 1'b0);
			push_crlf();
		end
	endtask

	task automatic add_multi();
		int cmax;
		int n;
		int i;
		cmax = (cur_max < 3) ? cur_max : 3;
		n = $urandom_range(cmax);
		push_b(rfv_pkg::CH_STAR, 1'b1);
		push_dec(64'(n));
		push_crlf();
		for (i = 0; i < n; i++)
			add_bulk(1'b0);
	endtask

	task automatic add_bad_header();
		int i;
		case ($urandom_range(5))
			0: begin
				// length reaching 2^LENGTH_BITS
				push_b(rfv_pkg::CH_DOLLAR, 1'b1);
				push_dec(longint'(1) << rfv_pkg::LENGTH_BITS_DEF);
			end
			1: begin
				push_b(rfv_pkg::CH_STAR, 1'b1);
				push_dec(64'(cur_max + 1));
				push_crlf();
			end
			2: begin
				push_str("$-", 1'b1);
				push_dec(64'($urandom_range(9, 2)));
				push_crlf();
			end
			3: begin
				// largest legal length, then only a few data bytes
				push_b(rfv_pkg::CH_DOLLAR, 1'b1);
				push_dec((longint'(1) << rfv_pkg::LENGTH_BITS_DEF) - 1);
				push_crlf();
				for (i = 0; i < 3; i++)
					push_b(8'($urandom_range(255)), 1'b0);
			end
			4: begin
				push_str("*-0", 1'b1);
				push_crlf();
			end
			default: begin
				push_str("*-", 1'b1);
				push_dec(64'($urandom_range(5, 1)));
				push_crlf();
			end
		endcase
	endtask

	task automatic break_frame();
		int idx;
		rfv_pkg::req_t r;
		case ($urandom_range(2))
			0: begin
				idx = $urandom_range(frame_q.size() - 1, 1);
				r = frame_q[idx];
				r.data_byte = 8'($urandom_range(255));
				frame_q[idx] = r;
			end
			1: begin
				idx = $urandom_range(frame_q.size() - 1, 1);
				while (frame_q.size() > idx)
					frame_q.delete(frame_q.size() - 1);
			end
			default: push_b(8'($urandom_range(255)), 1'b0);
		endcase
	endtask

	task automatic add_random_frame();
		int r;
		int n;
		int i;
		r = $urandom_range(99);
		if (r < 20)
			add_line();
		else if (r < 45)
			add_bulk(1'b1);
		else if (r < 65)
			add_multi();
		else if (r < 75) begin
			case ($urandom_range(2))
				0: add_line();
				1: add_bulk(1'b1);
				default: add_multi();
			endcase
			break_frame();
		end else if (r < 83)
			add_bad_header();
		else begin
			n = $urandom_range(4, 1);
			for (i = 0; i < n; i++)
				push_b(8'($urandom_range(255)), 1'($urandom_range(1)));
		end
	endtask

	task automatic run_phase(input int s_pct, input int r_pct, input phase_event_e ev);
		int start;
		bit ev_done;
		start = sent_count;
		ev_done = 1'b0;
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		while (sent_count - start < PHASE_ITEMS) begin
			if (!ev_done && sent_count - start >= 60) begin
				ev_done = 1'b1;
				if (ev == EV_LONG_HOLD)
					hold_token++;
				else if (ev == EV_PAUSE)
					drain();
			end
			add_random_frame();
			flush_frame();
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed replies, max_elements at its reset value
		push_b(8'hff, 1'b1);        // unknown type byte
		push_b(8'h00, 1'b0);        // error stays
		push_str("+", 1'b1);        // lone CR in the body, then CR LF
		push_b(rfv_pkg::CH_CR, 1'b0);
		push_crlf();
		push_str("x", 1'b0);        // byte after completion
		push_str("$-1", 1'b1);      // null bulk
		push_crlf();
		push_str("$1", 1'b1);       // data then a bad terminator
		push_crlf();
		push_str("a", 1'b0);
		push_b(rfv_pkg::CH_CR, 1'b0);
		push_str("X", 1'b0);
		push_str("*1025", 1'b1);    // count above max_elements
		push_crlf();
		push_str("*1", 1'b1);       // element that is not a bulk
		push_crlf();
		push_str("+", 1'b0);
		push_str("$-", 1'b1);       // header with no digit
		push_b(rfv_pkg::CH_CR, 1'b0);
		flush_frame();
		drain();

		write_max(3);
		run_phase(34, 47, EV_LONG_HOLD);
		drain();
		write_max(0);
		run_phase(47, 34, EV_PAUSE);
		drain();
		write_max(65535);
		run_phase(0, 0, EV_NONE);
		drain();

		$display("covered %0d requests over three idle modes, max_elements 1024, 3, 0, 65535",
			sent_count);
		$display("predicted %0d complete replies and %0d protocol error results",
			done_count, error_count);
		if (fail_count == 0 && open_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
